[src/assert_macros.svh]
// Assertion macros shared by the elevator stepper controller RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that prop holds at every edge outside reset.
`define ESC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that cond at one edge implies prop at the next edge, outside reset.
`define ESC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

[src/esc_pkg.sv]
// Shared types, codes and the coil table for the elevator stepper controller.
// No dependencies; every RTL module imports this package.
package esc_pkg;

  // Number of floors the select button cycles through (2 to 4 usable here).
  localparam int NUM_FLOORS = 4;

  // Motion mode codes.
  localparam logic [2:0] MODE_STOP      = 3'd0;
  localparam logic [2:0] MODE_UP        = 3'd1;
  localparam logic [2:0] MODE_DOWN      = 3'd2;
  localparam logic [2:0] MODE_CALL_UP   = 3'd3;
  localparam logic [2:0] MODE_CALL_DOWN = 3'd4;

  // Travel direction codes.
  localparam logic [1:0] DIR_CLOSED = 2'd0;
  localparam logic [1:0] DIR_IDLE   = 2'd1;
  localparam logic [1:0] DIR_RISE   = 2'd2;
  localparam logic [1:0] DIR_FALL   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_DWELL      = 2'd0;
  localparam logic [1:0] REG_OPEN_START = 2'd1;
  localparam logic [1:0] REG_OPEN_END   = 2'd2;
  localparam logic [1:0] REG_CALL_CLOSE = 2'd3;

  // Configuration reset values in milliseconds.
  localparam logic [15:0] DWELL_RST      = 16'd5000;
  localparam logic [15:0] OPEN_START_RST = 16'd1500;
  localparam logic [15:0] OPEN_END_RST   = 16'd3500;
  localparam logic [15:0] CALL_CLOSE_RST = 16'd2500;

  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] dwell_ms;
    logic [15:0] open_start_ms;
    logic [15:0] open_end_ms;
    logic [15:0] call_close_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0] current_floor;
    logic       at_floor;
    logic       call_down_press;
    logic       call_up_press;
    logic       next_floor_press;
    logic       confirm_press;
    logic       ms_tick;
  } item_t;

  typedef struct packed {
    logic [1:0] selected_floor_out;
    logic [3:0] floor_leds;
    logic [3:0] request_mask;
    logic [1:0] travel_direction;
    logic [2:0] motion_mode;
    logic       door_open;
    logic [3:0] coil_drive;
  } result_t;

  // Eight-phase half-step coil pattern.
  function automatic logic [3:0] coil_pattern(input logic [2:0] phase);
    logic [3:0] pat;
    case (phase)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

[src/esc_cfg_regs.sv]
// APB-style configuration registers for the elevator stepper controller.
// Depends on esc_pkg for the register indexes, reset values and cfg_t.
module esc_cfg_regs import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // Register writes at the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dwell_ms      <= DWELL_RST;
      cfg_r.open_start_ms <= OPEN_START_RST;
      cfg_r.open_end_ms   <= OPEN_END_RST;
      cfg_r.call_close_ms <= CALL_CLOSE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DWELL:      cfg_r.dwell_ms      <= pwdata[15:0];
        REG_OPEN_START: cfg_r.open_start_ms <= pwdata[15:0];
        REG_OPEN_END:   cfg_r.open_end_ms   <= pwdata[15:0];
        REG_CALL_CLOSE: cfg_r.call_close_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      REG_DWELL:      prdata = {16'd0, cfg_r.dwell_ms};
      REG_OPEN_START: prdata = {16'd0, cfg_r.open_start_ms};
      REG_OPEN_END:   prdata = {16'd0, cfg_r.open_end_ms};
      REG_CALL_CLOSE: prdata = {16'd0, cfg_r.call_close_ms};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

[src/esc_core.sv]
// Controller state and the per-item update of the elevator stepper controller.
// Depends on esc_pkg for codes, the coil table and the item/result types.
module esc_core import esc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res_nxt
);

  logic [2:0]  mode_r, mode_nxt;
  logic [1:0]  dir_r, dir_nxt;
  logic [3:0]  req_r, req_nxt;
  logic [1:0]  sel_r, sel_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic        door_cmd_r, door_cmd_nxt;
  logic        door_sent_r, door_sent_nxt;
  logic [3:0]  coil_r, coil_nxt;
  logic [3:0]  led_r, led_nxt;

  // Next state for one polling pass: tick, mode handler, confirm, next floor.
  always_comb begin
    logic [15:0] et;
    logic [3:0]  req_clr;
    logic [3:0]  cur_bit;
    logic [3:0]  sel_bit;
    logic [2:0]  sel_inc;

    mode_nxt      = mode_r;
    dir_nxt       = dir_r;
    req_nxt       = req_r;
    sel_nxt       = sel_r;
    phase_nxt     = phase_r;
    door_cmd_nxt  = door_cmd_r;
    door_sent_nxt = door_sent_r;
    coil_nxt      = coil_r;
    led_nxt       = led_r;

    // Saturating millisecond counter.
    et = (item.ms_tick && (elapsed_r != ELAPSED_MAX)) ? elapsed_r + 16'd1 : elapsed_r;
    elapsed_nxt = et;

    cur_bit = 4'b0001 << item.current_floor;
    req_clr = req_r & ~cur_bit;

    case (mode_r)
      MODE_STOP: begin
        door_sent_nxt = door_cmd_r;
        if (req_r == 4'd0) begin
          // Nothing requested: park and wait for a hall call.
          coil_nxt = coil_pattern(phase_r);
          dir_nxt  = DIR_CLOSED;
          if (item.call_up_press) begin
            elapsed_nxt  = 16'd0;
            dir_nxt      = DIR_IDLE;
            door_cmd_nxt = 1'b1;
            mode_nxt     = MODE_CALL_UP;
          end else if (item.call_down_press) begin
            elapsed_nxt  = 16'd0;
            dir_nxt      = DIR_IDLE;
            door_cmd_nxt = 1'b1;
            mode_nxt     = MODE_CALL_DOWN;
          end
        end else begin
          // Dwell at a served floor; the served request clears once it ends.
          if (et > cfg.dwell_ms) begin
            req_nxt = req_clr;
          end
          if (req_nxt == 4'd0) begin
            coil_nxt = coil_pattern(phase_r);
            dir_nxt  = DIR_CLOSED;
          end else if (et <= cfg.dwell_ms) begin
            door_cmd_nxt = (et > cfg.open_start_ms) && (et < cfg.open_end_ms);
            coil_nxt     = coil_pattern(phase_r);
          end else begin
            elapsed_nxt = 16'd0;
            if (dir_r == DIR_RISE) begin
              mode_nxt = MODE_UP;
            end else if (dir_r == DIR_FALL) begin
              mode_nxt = MODE_DOWN;
            end
          end
        end
      end
      MODE_UP, MODE_DOWN: begin
        // Step the coils on each tick and stop at a requested floor.
        dir_nxt = (mode_r == MODE_UP) ? DIR_RISE : DIR_FALL;
        if (item.ms_tick) begin
          coil_nxt  = coil_pattern(phase_r);
          phase_nxt = (mode_r == MODE_UP) ? phase_r + 3'd1 : phase_r - 3'd1;
        end
        if (((req_r & cur_bit) != 4'd0) && item.at_floor) begin
          led_nxt     = 4'd0;
          elapsed_nxt = 16'd0;
          mode_nxt    = MODE_STOP;
        end
      end
      MODE_CALL_UP, MODE_CALL_DOWN: begin
        // Door open after a hall call until the close time passes.
        door_sent_nxt = door_cmd_r;
        if (et > cfg.call_close_ms) begin
          door_cmd_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    // Confirm registers the selected floor when it lies ahead, or any floor while idle.
    sel_bit = 4'b0001 << sel_r;
    if (item.confirm_press) begin
      if (dir_nxt == DIR_IDLE) begin
        req_nxt = req_nxt | sel_bit;
        if (sel_r > item.current_floor) begin
          mode_nxt = MODE_UP;
        end else if (sel_r < item.current_floor) begin
          mode_nxt = MODE_DOWN;
        end
      end else if (dir_nxt == DIR_RISE && sel_r > item.current_floor) begin
        req_nxt = req_nxt | sel_bit;
      end else if (dir_nxt == DIR_FALL && sel_r < item.current_floor) begin
        req_nxt = req_nxt | sel_bit;
      end
    end

    // Floor select button wraps over the floor count.
    sel_inc = {1'b0, sel_r} + 3'd1;
    if (item.next_floor_press) begin
      sel_nxt = (int'(sel_inc) >= NUM_FLOORS) ? 2'd0 : sel_inc[1:0];
      led_nxt = 4'b0001 << sel_nxt;
    end
  end

  // Control state moves only when an item passes to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_STOP;
      dir_r       <= DIR_CLOSED;
      req_r       <= 4'd0;
      sel_r       <= 2'd0;
      phase_r     <= 3'd0;
      elapsed_r   <= 16'd0;
      door_cmd_r  <= 1'b0;
      door_sent_r <= 1'b0;
      coil_r      <= 4'd0;
      led_r       <= 4'd0;
    end else if (adv) begin
      mode_r      <= mode_nxt;
      dir_r       <= dir_nxt;
      req_r       <= req_nxt;
      sel_r       <= sel_nxt;
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      door_cmd_r  <= door_cmd_nxt;
      door_sent_r <= door_sent_nxt;
      coil_r      <= coil_nxt;
      led_r       <= led_nxt;
    end
  end

  // The result of a pass is the state it leaves behind.
  assign res_nxt.coil_drive         = coil_nxt;
  assign res_nxt.door_open          = door_sent_nxt;
  assign res_nxt.motion_mode        = mode_nxt;
  assign res_nxt.travel_direction   = dir_nxt;
  assign res_nxt.request_mask       = req_nxt;
  assign res_nxt.floor_leds         = led_nxt;
  assign res_nxt.selected_floor_out = sel_nxt;

endmodule

[src/elevator_stepper_controller.sv]
// Top level of the elevator stepper controller: input register, core, result register.
// Depends on esc_pkg, esc_cfg_regs, esc_core and assert_macros.svh.
//
//   channel  | direction | handshake          | payload
//   in_      | slave     | tvalid / tready    | tdata[7:0]  polling pass
//   out_     | master    | tvalid / tready    | tdata[23:0] controller status
//   cfg_     | slave     | psel / penable     | 4 x 16-bit timing registers
//
// One item per clock while out_tready is high; a result is offered from the result register.
// The rate is set by the combinational state update in the core between the two registers.
// Synchronous reset clears both registers' valid flags and all controller state.
// A stalled output holds its result while one more item waits in the input register.
module elevator_stepper_controller import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Fields from bit 0: ms_tick, confirm_press, next_floor_press, call_up_press,
  // call_down_press, at_floor, current_floor[1:0].
  input  logic [7:0]  in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: coil_drive[3:0], door_open, motion_mode[2:0],
  // travel_direction[1:0], request_mask[3:0], floor_leds[3:0],
  // selected_floor_out[1:0], then four zero bits.
  output logic [23:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

`include "assert_macros.svh"

  cfg_t    cfg;
  item_t   s1_item_r;
  logic    s1_valid_r;
  result_t res_nxt;
  result_t out_res_r;
  logic    out_valid_r;
  logic    adv;

  esc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // An item moves on when the result register is empty or being drained.
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= item_t'(in_tdata);
    end
  end

  esc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .item    (s1_item_r),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r};

  // Checks on the pipeline control.
  `ESC_ASSERT(a_stall_only_when_full, !in_tready |-> (s1_valid_r && out_valid_r && !out_tready), "input stalled while a stage is free")
  `ESC_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_r, "advanced item did not reach the result register")
  `ESC_ASSERT(a_reset_empties, !$past(rst_n) |-> (!out_valid_r && !s1_valid_r), "pipeline not empty after reset")

endmodule

[verif/tb_top.sv]
// Self-checking testbench for elevator_stepper_controller: streams polling passes,
// predicts every status item and compares it field by field, rewrites the timing registers.
// Depends on esc_pkg and the elevator_stepper_controller RTL only.
module tb_top import esc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  // Predicts the controller status after each polling pass and checks the results.
  class lift_status_board;
    logic [15:0] timing [4];
    logic [2:0]  mode;
    logic [1:0]  dir;
    logic [3:0]  reqs;
    logic [1:0]  sel;
    logic [2:0]  phase;
    logic [15:0] elapsed;
    logic        door_cmd;
    logic        door_sent;
    logic [3:0]  coil;
    logic [3:0]  leds;
    logic [3:0]  half_step [8];
    result_t     status_due [$];
    int          mismatches;
    int          checked;

    function new();
      half_step = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
      timing[REG_DWELL]      = DWELL_RST;
      timing[REG_OPEN_START] = OPEN_START_RST;
      timing[REG_OPEN_END]   = OPEN_END_RST;
      timing[REG_CALL_CLOSE] = CALL_CLOSE_RST;
      mode = MODE_STOP;
      dir = DIR_CLOSED;
      reqs = '0;
      sel = '0;
      phase = '0;
      elapsed = '0;
      door_cmd = 1'b0;
      door_sent = 1'b0;
      coil = '0;
      leds = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("[%0t] %s", $realtime, msg);
      end
    endfunction

    function string show(result_t r);
      return $sformatf("coil=%h door=%b mode=%0d dir=%0d req=%b led=%b sel=%0d",
                       r.coil_drive, r.door_open, r.motion_mode, r.travel_direction,
                       r.request_mask, r.floor_leds, r.selected_floor_out);
    endfunction

    // Stop mode: latch the door command, then either park, run the door window or resume.
    function void stop_pass();
      door_sent = door_cmd;
      if (reqs == '0) begin
        coil = half_step[phase];
        dir = DIR_CLOSED;
      end else if (elapsed <= timing[REG_DWELL]) begin
        door_cmd = (elapsed > timing[REG_OPEN_START]) && (elapsed < timing[REG_OPEN_END]);
        coil = half_step[phase];
      end else begin
        elapsed = '0;
        if (dir == DIR_RISE) begin
          mode = MODE_UP;
        end else if (dir == DIR_FALL) begin
          mode = MODE_DOWN;
        end
      end
    endfunction

    function void note_pass(item_t p);
      logic    up;
      result_t want;
      // The tick advances the saturating millisecond count before anything else.
      if (p.ms_tick && elapsed != ELAPSED_MAX) begin
        elapsed++;
      end
      case (mode)
        MODE_STOP: begin
          if (reqs == '0) begin
            stop_pass();
            if (p.call_up_press || p.call_down_press) begin
              elapsed = '0;
              dir = DIR_IDLE;
              door_cmd = 1'b1;
              mode = p.call_up_press ? MODE_CALL_UP : MODE_CALL_DOWN;
            end
          end else begin
            if (elapsed > timing[REG_DWELL]) begin
              reqs[p.current_floor] = 1'b0;
            end
            stop_pass();
          end
        end
        MODE_UP, MODE_DOWN: begin
          up = (mode == MODE_UP);
          dir = up ? DIR_RISE : DIR_FALL;
          if (p.ms_tick) begin
            coil = half_step[phase];
            phase = up ? phase + 3'd1 : phase - 3'd1;
          end
          if (reqs[p.current_floor] && p.at_floor) begin
            leds = '0;
            elapsed = '0;
            mode = MODE_STOP;
          end
        end
        MODE_CALL_UP, MODE_CALL_DOWN: begin
          door_sent = door_cmd;
          if (elapsed > timing[REG_CALL_CLOSE]) begin
            door_cmd = 1'b0;
          end
        end
        default: begin
        end
      endcase
      // A confirm only counts for a floor that lies ahead, or any floor while idle.
      if (p.confirm_press) begin
        if (dir == DIR_IDLE) begin
          reqs[sel] = 1'b1;
          if (sel > p.current_floor) begin
            mode = MODE_UP;
          end else if (sel < p.current_floor) begin
            mode = MODE_DOWN;
          end
        end else if (dir == DIR_RISE && sel > p.current_floor) begin
          reqs[sel] = 1'b1;
        end else if (dir == DIR_FALL && sel < p.current_floor) begin
          reqs[sel] = 1'b1;
        end
      end
      if (p.next_floor_press) begin
        sel = 2'((32'(sel) + 1) % NUM_FLOORS);
        leds = 4'b0001 << sel;
      end
      want.coil_drive = coil;
      want.door_open = door_sent;
      want.motion_mode = mode;
      want.travel_direction = dir;
      want.request_mask = reqs;
      want.floor_leds = leds;
      want.selected_floor_out = sel;
      status_due.push_back(want);
    endfunction

    function void check_status(result_t got);
      result_t want;
      if (status_due.size() == 0) begin
        report($sformatf("status item with no pass waiting: %s", show(got)));
        return;
      end
      want = status_due.pop_front();
      checked++;
      if (got.coil_drive !== want.coil_drive || got.door_open !== want.door_open ||
          got.motion_mode !== want.motion_mode ||
          got.travel_direction !== want.travel_direction ||
          got.request_mask !== want.request_mask || got.floor_leds !== want.floor_leds ||
          got.selected_floor_out !== want.selected_floor_out) begin
        report($sformatf("status mismatch: expected %s, got %s", show(want), show(got)));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic [7:0]  in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lift_status_board sb = new();
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  int n_passes = 0;
  int n_settings = 0;
  int quiet_cycles = 0;
  int car = 0;

  elevator_stepper_controller dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Status monitor and activity count for the watchdog.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_status(out_tdata[19:0]);
    end
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                  (cfg_psel && cfg_penable))) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
    $display("elevator_stepper_controller verification failed");
    $finish;
  end

  // Result side: random back-pressure, a steady stretch, and one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 25);
      end
    end
  end

  function automatic item_t pass_of(bit tk, bit cf, bit nx, bit cu, bit cd, bit af, int cur);
    item_t p;
    p.ms_tick = tk;
    p.confirm_press = cf;
    p.next_floor_press = nx;
    p.call_up_press = cu;
    p.call_down_press = cd;
    p.at_floor = af;
    p.current_floor = 2'(cur);
    return p;
  endfunction

  // Offers one pass and waits for it to be taken; valid stays up between back-to-back items.
  task automatic send_pass(item_t p);
    if (!steady && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tdata <= p;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_pass(p);
    n_passes++;
  endtask

  // Stops offering and waits until every predicted status item has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_xfer(bit wr, logic [3:0] addr, logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Writes one timing register with junk in the unused upper half, then reads it back.
  task automatic set_timing(int idx, logic [15:0] val);
    logic [31:0] rd;
    apb_xfer(1'b1, 4'(idx * 4), {16'($urandom), val}, rd);
    sb.timing[idx] = val;
    apb_xfer(1'b0, 4'(idx * 4), 32'h0, rd);
    if (rd[15:0] !== val) begin
      sb.report($sformatf("register %0d read back %h, wrote %h", idx, rd[15:0], val));
    end
  endtask

  task automatic set_all(logic [15:0] dwell, logic [15:0] opn, logic [15:0] cls,
                         logic [15:0] call_cls);
    set_timing(REG_DWELL, dwell);
    set_timing(REG_OPEN_START, opn);
    set_timing(REG_OPEN_END, cls);
    set_timing(REG_CALL_CLOSE, call_cls);
    n_settings++;
  endtask

  // One well-formed trip: hall call, floor choice, travel toward a requested floor, dwell.
  task automatic run_trip();
    int  pick;
    int  goal;
    int  hops;
    int  stay;
    int  lim;
    bit  arrive;
    pick = $urandom_range(3);
    send_pass(pass_of(1'($urandom), 0, 0, pick != 1, pick == 1 || pick == 2, 1, car));
    repeat ($urandom_range(0, 3)) send_pass(pass_of(1'($urandom), 0, 1, 0, 0, 1, car));
    send_pass(pass_of(1'($urandom), 1, 0, 0, 0, 1, car));
    if (sb.reqs != '0) begin
      do goal = $urandom_range(3); while (!sb.reqs[goal]);
    end else begin
      goal = sb.sel;
    end
    for (hops = 0; hops < 24 && sb.mode != MODE_STOP; hops++) begin
      if (goal != car && $urandom_range(2) == 0) begin
        car = (goal > car) ? car + 1 : car - 1;
        arrive = 1'b1;
      end else begin
        arrive = ($urandom_range(3) == 0);
      end
      send_pass(pass_of($urandom_range(9) != 0, $urandom_range(19) == 0,
                        $urandom_range(19) == 0, 0, 0, arrive, car));
    end
    lim = ((sb.timing[REG_DWELL] > 40) ? 40 : int'(sb.timing[REG_DWELL])) + 4;
    for (stay = 0; stay < lim && sb.mode == MODE_STOP && sb.reqs != '0; stay++) begin
      send_pass(pass_of(1, 0, 0, 0, 0, 1, car));
    end
  endtask

  // Mostly trips with random content, the rest raw noise passes.
  task automatic run_traffic(int n);
    int stop_at;
    stop_at = n_passes + n;
    while (n_passes < stop_at) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 8)) send_pass(item_t'(8'($urandom_range(255))));
      end else begin
        run_trip();
      end
    end
  endtask

  initial begin
    logic [15:0] d;
    int          tries;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full-range register values exercise every data bit of the port.
    set_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    set_all(16'd2, 16'd0, 16'd2, 16'd1);

    // Directed passes.
    send_pass(pass_of(0, 0, 0, 0, 0, 0, 0));
    send_pass(pass_of(1, 0, 0, 0, 0, 0, 0));
    // Confirm while closed is ignored.
    send_pass(pass_of(0, 1, 0, 0, 0, 1, 0));
    // Four presses wrap the selected floor.
    repeat (4) send_pass(pass_of(1, 0, 1, 0, 0, 0, 2));
    // Both hall calls at once: up wins.
    send_pass(pass_of(1, 0, 0, 1, 1, 1, 0));
    // Confirm at the current floor sets the request but keeps the call mode.
    send_pass(pass_of(0, 1, 0, 0, 0, 1, 0));
    repeat (2) send_pass(pass_of(1, 0, 0, 0, 0, 1, 0));
    send_pass(pass_of(0, 0, 1, 0, 0, 1, 0));
    send_pass(pass_of(0, 1, 0, 0, 0, 1, 0));
    send_pass(pass_of(1, 0, 0, 0, 0, 0, 0));
    send_pass(pass_of(1, 0, 0, 0, 0, 1, 1));
    // Confirm for a floor not ahead while rising is ignored.
    send_pass(pass_of(0, 1, 0, 0, 0, 1, 1));
    repeat (3) send_pass(pass_of(1, 0, 0, 0, 0, 1, 1));
    send_pass(pass_of(1, 0, 0, 0, 0, 1, 0));
    repeat (3) send_pass(pass_of(1, 0, 0, 0, 0, 1, 0));
    send_pass(pass_of(0, 0, 0, 0, 1, 1, 3));
    send_pass(item_t'(8'hFF));
    drain();

    // Random traffic under several timing settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_all(16'd0, 16'd0, 16'd0, 16'd0);
        2: set_all(16'd20, 16'd5, 16'hFFFF, 16'hFFFF);
        4: set_all(16'd1, 16'd0, 16'd1, 16'd3);
        default: begin
          d = 16'($urandom_range(1, 12));
          set_all(d, 16'($urandom_range(0, d)), 16'($urandom_range(0, d + 2)),
                  16'($urandom_range(0, 6)));
        end
      endcase
      if (ph == 1) begin
        hold_req = 1'b1;
      end
      if (ph == 3) begin
        steady = 1'b1;
      end
      run_traffic(115);
      if (ph == 2) begin
        drain();
      end
      run_traffic(115);
      steady = 1'b0;
      drain();
    end

    // Held dwell: with the longest dwell time the car stays parked at a served floor.
    set_all(16'hFFFF, 16'hFFFD, 16'hFFFF, 16'hFFFF);
    tries = 0;
    while (!(sb.mode == MODE_STOP && sb.reqs != '0) && tries < 50) begin
      run_trip();
      tries++;
    end
    steady = 1'b1;
    repeat (40) send_pass(pass_of(1, 0, 0, 0, 0, 1, car));
    steady = 1'b0;
    drain();
    set_all(16'd2, 16'd0, 16'd2, 16'd1);
    run_traffic(60);
    drain();
    repeat (10) @(posedge clk);

    $display("Sent %0d polling passes and checked %0d status items under %0d timing settings,",
             n_passes, sb.checked, n_settings);
    $display("with hall calls, trips, dwells, wraps and a dwell held at its longest setting.");
    if (sb.mismatches == 0 && sb.status_due.size() == 0) begin
      $display("elevator_stepper_controller verification clean");
    end else begin
      $display("%0d mismatches, %0d status items still due", sb.mismatches,
               sb.status_due.size());
      $display("elevator_stepper_controller verification failed");
    end
    $finish;
  end

endmodule
